[design/tree_path_distance_engine_macros.svh]
// Shared assertion macros for the tree path distance engine.
`ifndef TREE_PATH_DISTANCE_ENGINE_MACROS_SVH
`define TREE_PATH_DISTANCE_ENGINE_MACROS_SVH

// Same-cycle implication.
`define TPDE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpde assertion failed");

// Next-cycle implication.
`define TPDE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpde assertion failed");

`endif

[design/tpde_pkg.sv]
`timescale 1ns / 1ps
package tpde_pkg;
  localparam int MAX_VERTICES = 1024;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = VIDX_W + 1;
  localparam int WEIGHT_BITS  = 16;
  localparam int LEN_W        = 26;

  localparam logic [1:0] KIND_EDGE  = 2'd0;
  localparam logic [1:0] KIND_BUILD = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef struct packed {
    logic [1:0]             kind;
    logic [VIDX_W-1:0]      vertex_a;
    logic [VIDX_W-1:0]      vertex_b;
    logic [WEIGHT_BITS-1:0] edge_weight;
  } req_t;

  typedef struct packed {
    logic [LEN_W-1:0] path_length;
    logic             status;
  } rsp_t;

  typedef struct packed {
    logic [VIDX_W-1:0]      end_a;
    logic [VIDX_W-1:0]      end_b;
    logic [WEIGHT_BITS-1:0] cost;
  } edge_t;

  typedef struct packed {
    logic                   reached;
    logic [VIDX_W-1:0]      parent;
    logic [WEIGHT_BITS-1:0] cost;
    logic [VIDX_W-1:0]      level;
  } vert_t;
endpackage

[design/tpde_ram.sv]
`timescale 1ns / 1ps
module tpde_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[design/tree_path_distance_engine.sv]
`timescale 1ns / 1ps
// Weighted tree path distance engine.
// Requests arrive on in_valid_i / in_stall_o / in_req_i; results leave on
// out_valid_o / out_stall_i / out_rsp_o. A request is taken when valid is high
// and stall is low. Only a query request (kind 2) yields a result.
// Edge request: written to the edge memory when its ends differ, lie below
// the vertex count and the table has room. Build request: a clearing sweep
// over all MAX_VERTICES vertex memory entries, then a breadth-first walk from
// vertex 0 that scans every held edge for every reached vertex.
// Query: both vertex entries are fetched, then one climb step per tree level
// on the longer side, then the result goes to the output register; an
// out-of-range vertex or an unbuilt tree answers without reading the vertex
// memory, an unreached vertex once both entries are fetched.
// The block takes a new request once its own work is done, even while a result
// waits in the output register; a query finished behind a stalled result
// waits until that one is taken.
// Reset empties the edge table, clears the output valid and marks the tree unbuilt,
// so queries give status 1 until the first build. vertex_count resets to 1024.
module tree_path_distance_engine
  import tpde_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_rsp_o
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_POP   = 4'd3;
  localparam logic [3:0] S_XRD   = 4'd4;
  localparam logic [3:0] S_XLV   = 4'd5;
  localparam logic [3:0] S_ERD   = 4'd6;
  localparam logic [3:0] S_EDW   = 4'd7;
  localparam logic [3:0] S_YCK   = 4'd8;
  localparam logic [3:0] S_QRU   = 4'd9;
  localparam logic [3:0] S_QRV   = 4'd10;
  localparam logic [3:0] S_QSTEP = 4'd11;
  localparam logic [3:0] S_QDONE = 4'd12;

  logic [3:0]             state_q, state_d;
  logic [10:0]            vcount_q;
  logic [CNT_W-1:0]       held_q, held_d;
  logic                   built_q, built_d;
  logic [VIDX_W-1:0]      clr_q, clr_d;
  logic [CNT_W-1:0]       head_q, head_d, tail_q, tail_d, eidx_q, eidx_d;
  logic [VIDX_W-1:0]      x_q, x_d, y_q, y_d, lvlx_q, lvlx_d;
  logic [WEIGHT_BITS-1:0] ycost_q, ycost_d;
  logic [VIDX_W-1:0]      u_q, u_d, v_q, v_d;
  vert_t                  eu_q, eu_d, ev_q, ev_d;
  logic [LEN_W-1:0]       sum_q, sum_d;
  rsp_t                   res_q, res_d, out_q, out_d;
  logic                   outv_q, outv_d;

  logic [CNT_W-1:0] nlive;
  logic             accept;

  logic              e_we;
  logic [VIDX_W-1:0] e_waddr, e_raddr;
  edge_t             e_wdata, e_rdata;
  logic              vx_we;
  logic [VIDX_W-1:0] vx_waddr, vx_raddr;
  vert_t             vx_wdata, vx_rdata;
  logic              q_we;
  logic [VIDX_W-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

  tpde_ram #(.Width($bits(edge_t)), .Depth(MAX_VERTICES)) u_edge_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );
  tpde_ram #(.Width($bits(vert_t)), .Depth(MAX_VERTICES)) u_vert_ram (
    .clk_i, .we_i(vx_we), .waddr_i(vx_waddr), .wdata_i(vx_wdata),
    .raddr_i(vx_raddr), .rdata_o(vx_rdata)
  );
  tpde_ram #(.Width(VIDX_W), .Depth(MAX_VERTICES)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  always_comb begin
    if (vcount_q == '0) begin
      nlive = CNT_W'(1);
    end else if (vcount_q > 11'(MAX_VERTICES)) begin
      nlive = CNT_W'(MAX_VERTICES);
    end else begin
      nlive = CNT_W'(vcount_q);
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = outv_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    state_d = state_q;
    held_d  = held_q;
    built_d = built_q;
    clr_d   = clr_q;
    head_d  = head_q;
    tail_d  = tail_q;
    eidx_d  = eidx_q;
    x_d     = x_q;
    y_d     = y_q;
    lvlx_d  = lvlx_q;
    ycost_d = ycost_q;
    u_d     = u_q;
    v_d     = v_q;
    eu_d    = eu_q;
    ev_d    = ev_q;
    sum_d   = sum_q;
    res_d   = res_q;
    out_d   = out_q;
    outv_d  = outv_q;
    e_we     = 1'b0;
    e_waddr  = held_q[VIDX_W-1:0];
    e_wdata  = '{end_a: in_req_i.vertex_a, end_b: in_req_i.vertex_b,
                 cost: in_req_i.edge_weight};
    e_raddr  = eidx_q[VIDX_W-1:0];
    vx_we    = 1'b0;
    vx_waddr = clr_q;
    vx_wdata = '0;
    vx_raddr = u_q;
    q_we     = 1'b0;
    q_waddr  = tail_q[VIDX_W-1:0];
    q_wdata  = y_q;
    q_raddr  = head_q[VIDX_W-1:0];

    if (outv_q && !out_stall_i) begin
      outv_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_req_i.kind)
            KIND_EDGE: begin
              if (in_req_i.vertex_a != in_req_i.vertex_b &&
                  CNT_W'(in_req_i.vertex_a) < nlive &&
                  CNT_W'(in_req_i.vertex_b) < nlive &&
                  held_q < CNT_W'(MAX_VERTICES)) begin
                e_we   = 1'b1;
                held_d = held_q + 1'b1;
              end
            end
            KIND_BUILD: begin
              clr_d   = '0;
              state_d = S_CLR;
            end
            KIND_QUERY: begin
              u_d   = in_req_i.vertex_a;
              v_d   = in_req_i.vertex_b;
              sum_d = '0;
              if (CNT_W'(in_req_i.vertex_a) >= nlive ||
                  CNT_W'(in_req_i.vertex_b) >= nlive || !built_q) begin
                res_d   = '{path_length: '0, status: ST_ERR};
                state_d = S_QDONE;
              end else begin
                vx_raddr = in_req_i.vertex_a;
                state_d  = S_QRU;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        vx_we    = 1'b1;
        vx_waddr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == VIDX_W'(MAX_VERTICES - 1)) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        vx_we    = 1'b1;
        vx_waddr = '0;
        vx_wdata = '{reached: 1'b1, parent: '0, cost: '0, level: '0};
        q_we     = 1'b1;
        q_waddr  = '0;
        q_wdata  = '0;
        head_d   = '0;
        tail_d   = CNT_W'(1);
        built_d  = 1'b1;
        state_d  = S_POP;
      end
      S_POP: begin
        if (head_q == tail_q) begin
          state_d = S_IDLE;
        end else begin
          q_raddr = head_q[VIDX_W-1:0];
          head_d  = head_q + 1'b1;
          state_d = S_XRD;
        end
      end
      S_XRD: begin
        x_d      = q_rdata;
        vx_raddr = q_rdata;
        state_d  = S_XLV;
      end
      S_XLV: begin
        lvlx_d  = vx_rdata.level;
        eidx_d  = '0;
        state_d = S_ERD;
      end
      S_ERD: begin
        if (eidx_q == held_q) begin
          state_d = S_POP;
        end else begin
          e_raddr = eidx_q[VIDX_W-1:0];
          eidx_d  = eidx_q + 1'b1;
          state_d = S_EDW;
        end
      end
      S_EDW: begin
        state_d = S_ERD;
        if (CNT_W'(e_rdata.end_a) < nlive && CNT_W'(e_rdata.end_b) < nlive &&
            (e_rdata.end_a == x_q || e_rdata.end_b == x_q)) begin
          y_d      = (e_rdata.end_a == x_q) ? e_rdata.end_b : e_rdata.end_a;
          vx_raddr = y_d;
          ycost_d  = e_rdata.cost;
          state_d  = S_YCK;
        end
      end
      S_YCK: begin
        if (!vx_rdata.reached) begin
          vx_we    = 1'b1;
          vx_waddr = y_q;
          vx_wdata = '{reached: 1'b1, parent: x_q, cost: ycost_q,
                       level: lvlx_q + 1'b1};
          if (tail_q < CNT_W'(MAX_VERTICES)) begin
            q_we   = 1'b1;
            tail_d = tail_q + 1'b1;
          end
        end
        state_d = S_ERD;
      end
      S_QRU: begin
        eu_d     = vx_rdata;
        vx_raddr = v_q;
        state_d  = S_QRV;
      end
      S_QRV: begin
        ev_d = vx_rdata;
        if (!eu_q.reached || !vx_rdata.reached) begin
          res_d   = '{path_length: '0, status: ST_ERR};
          state_d = S_QDONE;
        end else begin
          state_d = S_QSTEP;
        end
      end
      S_QSTEP: begin
        state_d = S_QRU;
        priority if (u_q == v_q) begin
          res_d   = '{path_length: sum_q, status: ST_OK};
          state_d = S_QDONE;
        end else if (eu_q.level > ev_q.level) begin
          sum_d    = sum_q + LEN_W'(eu_q.cost);
          u_d      = eu_q.parent;
          vx_raddr = eu_q.parent;
        end else if (ev_q.level > eu_q.level) begin
          sum_d    = sum_q + LEN_W'(ev_q.cost);
          v_d      = ev_q.parent;
          vx_raddr = u_q;
        end else begin
          sum_d    = sum_q + LEN_W'(eu_q.cost) + LEN_W'(ev_q.cost);
          u_d      = eu_q.parent;
          v_d      = ev_q.parent;
          vx_raddr = eu_q.parent;
        end
      end
      S_QDONE: begin
        if (!outv_q || !out_stall_i) begin
          outv_d  = 1'b1;
          out_d   = res_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vcount_q <= 11'(MAX_VERTICES);
      held_q   <= '0;
      built_q  <= 1'b0;
      outv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      held_q  <= held_d;
      built_q <= built_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clr_q   <= clr_d;
    head_q  <= head_d;
    tail_q  <= tail_d;
    eidx_q  <= eidx_d;
    x_q     <= x_d;
    y_q     <= y_d;
    lvlx_q  <= lvlx_d;
    ycost_q <= ycost_d;
    u_q     <= u_d;
    v_q     <= v_d;
    eu_q    <= eu_d;
    ev_q    <= ev_d;
    sum_q   <= sum_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end
endmodule

[design/tpde_checker.sv]
`timescale 1ns / 1ps
`include "tree_path_distance_engine_macros.svh"
module tpde_checker
  import tpde_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input req_t        in_req_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input rsp_t        out_rsp_o
);
  `TPDE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `TPDE_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_rsp_o))
  `TPDE_ASSERT_NOW(a_err_zero, out_valid_o && out_rsp_o.status == ST_ERR, out_rsp_o.path_length == '0)
  `TPDE_ASSERT_NEXT(a_edge_one_cycle, in_valid_i && !in_stall_o && in_req_i.kind == KIND_EDGE, !in_stall_o)
endmodule

bind tree_path_distance_engine tpde_checker u_tpde_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
  .out_valid_o, .out_stall_i, .out_rsp_o
);

[bench/tb_tree_path_distance_engine.sv]
`timescale 1ns / 1ps
module tb_tree_path_distance_engine;
  import tpde_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  rsp_t out_rsp_o;

  tree_path_distance_engine DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_rsp_o(out_rsp_o)
  );

  initial forever #5 clk_i = ~clk_i;

  // tree model
  logic [10:0]            count_reg;
  logic [VIDX_W-1:0]      edge_a [MAX_VERTICES];
  logic [VIDX_W-1:0]      edge_b [MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] edge_w [MAX_VERTICES];
  int                     edge_total;
  logic [VIDX_W-1:0]      up_vertex [MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] up_cost [MAX_VERTICES];
  int                     depth_of [MAX_VERTICES];
  bit                     on_tree [MAX_VERTICES];
  rsp_t                   pending_dist [$];

  int fails = 0;
  int gap_max = 11;
  int stall_max = 11;
  int n_req = 0;
  int n_rsp = 0;
  int n_builds = 0;
  int attached [$];

  function automatic int live_n();
    if (count_reg < 1) return 1;
    if (count_reg > MAX_VERTICES) return MAX_VERTICES;
    return count_reg;
  endfunction

  function automatic void walk_tree();
    int n, x, y;
    int fifo [$];
    n = live_n();
    foreach (on_tree[i]) on_tree[i] = 1'b0;
    on_tree[0] = 1'b1;
    up_vertex[0] = '0;
    up_cost[0] = '0;
    depth_of[0] = 0;
    fifo = {fifo, 0};
    while (fifo.size() > 0) begin
      x = fifo.pop_front();
      for (int i = 0; i < edge_total; i++) begin
        if (edge_a[i] >= n || edge_b[i] >= n) continue;
        if (edge_a[i] == x) y = edge_b[i];
        else if (edge_b[i] == x) y = edge_a[i];
        else continue;
        if (on_tree[y]) continue;
        on_tree[y] = 1'b1;
        up_vertex[y] = VIDX_W'(x);
        up_cost[y] = edge_w[i];
        depth_of[y] = depth_of[x] + 1;
        fifo = {fifo, y};
      end
    end
  endfunction

  function automatic rsp_t path_dist(int u, int v);
    rsp_t r;
    longint sum;
    int guard;
    r = '0;
    sum = 0;
    guard = 0;
    if (u >= live_n() || v >= live_n() || !on_tree[u] || !on_tree[v]) begin
      r.status = ST_ERR;
      return r;
    end
    while (u != v && guard < 2 * MAX_VERTICES) begin
      guard++;
      if (depth_of[u] > depth_of[v]) begin
        sum += up_cost[u];
        u = up_vertex[u];
      end else if (depth_of[v] > depth_of[u]) begin
        sum += up_cost[v];
        v = up_vertex[v];
      end else begin
        sum += up_cost[u] + up_cost[v];
        u = up_vertex[u];
        v = up_vertex[v];
      end
    end
    r.path_length = (sum > (64'd1 << LEN_W) - 1) ? {LEN_W{1'b1}} : sum[LEN_W-1:0];
    r.status = ST_OK;
    return r;
  endfunction

  function automatic void apply_req(req_t r);
    int n;
    n = live_n();
    case (r.kind)
      KIND_EDGE: begin
        if (r.vertex_a != r.vertex_b && r.vertex_a < n && r.vertex_b < n &&
            edge_total < MAX_VERTICES) begin
          edge_a[edge_total] = r.vertex_a;
          edge_b[edge_total] = r.vertex_b;
          edge_w[edge_total] = r.edge_weight;
          edge_total++;
        end
      end
      KIND_BUILD: begin
        walk_tree();
        n_builds++;
      end
      KIND_QUERY: pending_dist = {pending_dist, path_dist(r.vertex_a, r.vertex_b)};
      default: ;
    endcase
  endfunction

  task automatic send_req(logic [1:0] kind, int a, int b, int w);
    req_t r;
    int gap;
    r.kind = kind;
    r.vertex_a = VIDX_W'(a);
    r.vertex_b = VIDX_W'(b);
    r.edge_weight = WEIGHT_BITS'(w);
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    apply_req(r);
    n_req++;
  endtask

  // a trailing query guarantees any build has finished once it is answered
  task automatic drain();
    send_req(KIND_QUERY, 0, 0, 0);
    in_valid_i <= 1'b0;
    while (pending_dist.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_count(int v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 11'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    count_reg = 11'(v);
  endtask

  // result side
  int hold = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_rsp++;
        if (pending_dist.size() == 0) begin
          $error("unexpected request result: path_length %0d status %0d",
                 out_rsp_o.path_length, out_rsp_o.status);
          fails++;
        end else begin
          rsp_t e;
          e = pending_dist.pop_front();
          if (out_rsp_o.path_length !== e.path_length) begin
            $error("path_length expected %0d actual %0d", e.path_length,
                   out_rsp_o.path_length);
            fails++;
          end
          if (out_rsp_o.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_rsp_o.status);
            fails++;
          end
        end
        hold = $urandom_range(stall_max, 0);
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic test_before_build();
    send_req(KIND_QUERY, 0, 0, 0);
    send_req(KIND_QUERY, 1023, 5, 0);
    send_req(KIND_EDGE, 0, 1, 10);
    send_req(KIND_QUERY, 0, 1, 0);
    drain();
  endtask

  task automatic test_directed();
    set_count(8);
    send_req(KIND_EDGE, 3, 3, 99);
    send_req(KIND_EDGE, 2, 9, 5);
    send_req(KIND_EDGE, 1023, 1023, 65535);
    send_req(KIND_EDGE, 1, 2, 0);
    send_req(KIND_EDGE, 0, 3, 1234);
    send_req(KIND_EDGE, 2, 1, 7);
    send_req(KIND_EDGE, 3, 2, 65535);
    send_req(KIND_EDGE, 4, 3, 21845);
    send_req(KIND_SPARE, 682, 341, 43690);
    send_req(KIND_BUILD, 0, 0, 0);
    send_req(KIND_QUERY, 2, 4, 0);
    send_req(KIND_QUERY, 4, 1, 0);
    send_req(KIND_QUERY, 2, 2, 0);
    send_req(KIND_QUERY, 6, 6, 0);
    send_req(KIND_QUERY, 1023, 0, 0);
    send_req(KIND_QUERY, 0, 7, 0);
    send_req(KIND_QUERY, 3, 1, 0);
    drain();
  endtask

  task automatic test_count_extremes();
    set_count(3);
    send_req(KIND_BUILD, 0, 0, 0);
    send_req(KIND_QUERY, 1, 2, 0);
    send_req(KIND_QUERY, 4, 0, 0);
    set_count(0);
    send_req(KIND_BUILD, 0, 0, 0);
    send_req(KIND_QUERY, 0, 0, 0);
    send_req(KIND_QUERY, 0, 1, 0);
    set_count(2047);
    send_req(KIND_BUILD, 0, 0, 0);
    send_req(KIND_QUERY, 4, 2, 0);
    drain();
  endtask

  task automatic test_random_trees();
    int n, u, v, pick;
    attached = '{0, 1, 2, 3, 4};
    for (int round = 0; round < 6; round++) begin
      n = (round == 5) ? 1024 : $urandom_range(1024, 16);
      if (round == 3) begin
        gap_max = 0;
        stall_max = 0;
      end else begin
        gap_max = 11;
        stall_max = 11;
      end
      set_count(n);
      for (int k = 0; k < 14; k++) begin
        pick = $urandom_range(9, 0);
        if (pick < 7) begin
          u = attached[$urandom_range(attached.size() - 1, 0)];
          v = $urandom_range(n - 1, 0);
          send_req(KIND_EDGE, u, v, $urandom_range(65535, 0));
          if (u < n) attached = {attached, v};
        end else if (pick == 7) begin
          send_req(KIND_EDGE, $urandom_range(1023, 0), $urandom_range(1023, 0),
                   $urandom_range(65535, 0));
        end else if (pick == 8) begin
          u = $urandom_range(1023, 0);
          send_req(KIND_EDGE, u, u, $urandom_range(65535, 0));
        end else begin
          send_req(KIND_SPARE, $urandom_range(1023, 0), $urandom_range(1023, 0),
                   $urandom_range(65535, 0));
        end
      end
      send_req(KIND_BUILD, 0, 0, 0);
      for (int k = 0; k < 24; k++) begin
        if ($urandom_range(4, 0) > 0)
          send_req(KIND_QUERY, attached[$urandom_range(attached.size() - 1, 0)],
                   attached[$urandom_range(attached.size() - 1, 0)], $urandom_range(65535, 0));
        else
          send_req(KIND_QUERY, $urandom_range(1023, 0), $urandom_range(1023, 0),
                   $urandom_range(65535, 0));
      end
    end
    gap_max = 11;
    stall_max = 11;
    drain();
  endtask

  task automatic test_paced_queries();
    for (int k = 0; k < 6; k++) begin
      send_req(KIND_QUERY, attached[$urandom_range(attached.size() - 1, 0)],
               attached[$urandom_range(attached.size() - 1, 0)], 0);
      in_valid_i <= 1'b0;
      while (pending_dist.size() > 0) @(posedge clk_i);
    end
  endtask

  task automatic test_high_vertex();
    set_count(1024);
    send_req(KIND_EDGE, 0, 1023, 77);
    send_req(KIND_BUILD, 0, 0, 0);
    for (int k = 0; k < 10; k++)
      send_req(KIND_QUERY, attached[$urandom_range(attached.size() - 1, 0)],
               (k < 5) ? 1023 : attached[$urandom_range(attached.size() - 1, 0)], 0);
    drain();
  endtask

  initial begin
    count_reg = 11'd1024;
    edge_total = 0;
    foreach (on_tree[i]) on_tree[i] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_before_build();
    test_directed();
    test_count_extremes();
    test_random_trees();
    test_paced_queries();
    test_high_vertex();
    in_valid_i <= 1'b0;
    while (pending_dist.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d requests, %0d results checked, %0d tree builds,", n_req, n_rsp,
             n_builds);
    $display("vertex counts from clamped low to clamped high and the top vertex on the tree.");
    if (fails == 0) begin
      $display("tree_path_distance_engine test passed");
    end else begin
      $display("tree_path_distance_engine test failed");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("tree_path_distance_engine test failed");
    $finish;
  end
endmodule

[files.f]
+incdir+design
design/tpde_pkg.sv
design/tpde_ram.sv
design/tree_path_distance_engine.sv
design/tpde_checker.sv
bench/tb_tree_path_distance_engine.sv
